// File: hw/rtl/srtsbe_pkg.sv
package srtsbe_pkg;

    localparam int READY_DEPTH = 16;
    localparam int IDX_W       = $clog2(READY_DEPTH);
    localparam int EST_W       = 20;
    localparam int PID_W       = 16;
    localparam int ORD_W       = 16;
    localparam int ALPHA_W     = 9;
    localparam int PROD_W      = EST_W + ALPHA_W;

    localparam logic [EST_W-1:0]   EST_MAX = {EST_W{1'b1}};
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(256);
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(128);

    // Input modes.
    localparam logic [2:0] MODE_ADMIT   = 3'd0;
    localparam logic [2:0] MODE_TICK    = 3'd1;
    localparam logic [2:0] MODE_PREEMPT = 3'd2;
    localparam logic [2:0] MODE_BLOCK   = 3'd3;
    localparam logic [2:0] MODE_FINISH  = 3'd4;

    // Result events.
    localparam logic [2:0] EV_DISPATCH = 3'd0;
    localparam logic [2:0] EV_PREEMPT  = 3'd1;
    localparam logic [2:0] EV_BLOCKED  = 3'd2;
    localparam logic [2:0] EV_FINISHED = 3'd3;
    localparam logic [2:0] EV_REJECT   = 3'd4;

    // Configuration register indexes.
    localparam logic CFG_POLICY = 1'b0;
    localparam logic CFG_ALPHA  = 1'b1;

    typedef struct packed {
        logic [2:0]       mode;
        logic [PID_W-1:0] task_id;
        logic [EST_W-1:0] initial_estimate;
    } in_t;

    typedef struct packed {
        logic [2:0]       event_res;
        logic [PID_W-1:0] task_out;
        logic [EST_W-1:0] estimate_out;
        logic             last;
    } out_t;

    typedef struct packed {
        logic load;
        logic scan_clear;
        logic scan_step;
        logic act;
        logic post;
        logic push_a;
        logic push_d;
    } cmd_t;

    typedef struct packed {
        logic scan_last;
        logic a_valid;
        logic d_valid;
        logic q_full;
    } stat_t;

endpackage

// File: hw/rtl/srtsbe_ctrl.sv
module srtsbe_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  srtsbe_pkg::stat_t  stat,
    output srtsbe_pkg::cmd_t   cmd
);
    import srtsbe_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN1 = 3'd1;
    localparam logic [2:0] S_ACT   = 3'd2;
    localparam logic [2:0] S_SCAN2 = 3'd3;
    localparam logic [2:0] S_POST  = 3'd4;
    localparam logic [2:0] S_PUSHA = 3'd5;
    localparam logic [2:0] S_PUSHD = 3'd6;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load       = 1'b1;
                    cmd.scan_clear = 1'b1;
                    state_next     = S_SCAN1;
                end
            end
            S_SCAN1:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_ACT;
                end
            end
            S_ACT:
            begin
                cmd.act        = 1'b1;
                cmd.scan_clear = 1'b1;
                state_next     = S_SCAN2;
            end
            S_SCAN2:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_POST;
                end
            end
            S_POST:
            begin
                cmd.post   = 1'b1;
                state_next = S_PUSHA;
            end
            S_PUSHA:
            begin
                if (!stat.a_valid)
                begin
                    state_next = S_PUSHD;
                end
                else if (!stat.q_full)
                begin
                    cmd.push_a = 1'b1;
                    state_next = S_PUSHD;
                end
            end
            S_PUSHD:
            begin
                if (!stat.d_valid)
                begin
                    state_next = S_IDLE;
                end
                else if (!stat.q_full)
                begin
                    cmd.push_d = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_SCAN1))
        else $error("accepted item did not start the table scan");

endmodule

// File: hw/rtl/srtsbe_dp.sv
module srtsbe_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  srtsbe_pkg::cmd_t   cmd,
    output srtsbe_pkg::stat_t  stat,
    input  srtsbe_pkg::in_t    in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output srtsbe_pkg::out_t   out_data,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [srtsbe_pkg::ALPHA_W-1:0] cfg_wdata
);
    import srtsbe_pkg::*;

    // Ready table.
    logic [PID_W-1:0] tbl_pid   [READY_DEPTH];
    logic [EST_W-1:0] tbl_est   [READY_DEPTH];
    logic [ORD_W-1:0] tbl_order [READY_DEPTH];
    logic [READY_DEPTH-1:0] valid_reg, valid_next;

    logic             policy_reg;
    logic [ALPHA_W-1:0] alpha_reg;

    in_t              item_reg;
    logic [ORD_W-1:0] counter_reg, counter_next;
    logic             run_valid_reg, run_valid_next;
    logic [PID_W-1:0] run_pid_reg, run_pid_next;
    logic [EST_W-1:0] run_est_reg, run_est_next;
    logic [EST_W-1:0] elapsed_reg, elapsed_next;
    logic             pending_reg, pending_next;
    logic             admitted_reg, admitted_next;

    logic             a_valid_reg, a_valid_next;
    out_t             a_reg, a_next;
    logic             d_valid_reg, d_valid_next;
    out_t             d_reg, d_next;

    // Scan state.
    logic [IDX_W-1:0] idx_reg;
    logic             free_found_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic             best_found_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic [PID_W-1:0] best_pid_reg;
    logic [EST_W-1:0] best_est_reg;
    logic [ORD_W-1:0] best_age_reg;

    // Result queue, two entries.
    out_t             q_mem [2];
    logic             q_wp_reg, q_rp_reg;
    logic [1:0]       q_cnt_reg;

    // Table write port.
    logic             tbl_we;
    logic [IDX_W-1:0] tbl_widx;
    logic [PID_W-1:0] tbl_wpid;
    logic [EST_W-1:0] tbl_west;

    logic [ORD_W-1:0] cand_age;
    logic             cand_beats;
    logic             cand_valid;
    logic [ALPHA_W-1:0] alpha_eff;
    logic [PROD_W-1:0] prod_old, prod_new;
    logic [PROD_W:0]   blend_sum;
    logic [EST_W-1:0]  blend_est;
    logic              stays;
    logic              q_push, q_pop;
    out_t              q_wdata;

    always_comb
    begin
        cand_valid = valid_reg[idx_reg];
        cand_age   = counter_reg - tbl_order[idx_reg];
        if (policy_reg && tbl_est[idx_reg] != best_est_reg)
        begin
            cand_beats = tbl_est[idx_reg] < best_est_reg;
        end
        else if (policy_reg && tbl_pid[idx_reg] != best_pid_reg)
        begin
            cand_beats = tbl_pid[idx_reg] < best_pid_reg;
        end
        else
        begin
            cand_beats = cand_age > best_age_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            free_found_reg <= 1'b0;
            best_found_reg <= 1'b0;
        end
        else if (cmd.scan_clear)
        begin
            idx_reg        <= '0;
            free_found_reg <= 1'b0;
            best_found_reg <= 1'b0;
        end
        else if (cmd.scan_step)
        begin
            idx_reg <= idx_reg + 1'b1;
            if (!free_found_reg && !cand_valid)
            begin
                free_found_reg <= 1'b1;
            end
            if (cand_valid && (!best_found_reg || cand_beats))
            begin
                best_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_step)
        begin
            if (!free_found_reg && !cand_valid)
            begin
                free_idx_reg <= idx_reg;
            end
            if (cand_valid && (!best_found_reg || cand_beats))
            begin
                best_idx_reg <= idx_reg;
                best_pid_reg <= tbl_pid[idx_reg];
                best_est_reg <= tbl_est[idx_reg];
                best_age_reg <= cand_age;
            end
        end
    end

    // Blocked estimate: weighted average with alpha in Q1.8, rounded half up.
    always_comb
    begin
        alpha_eff = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
        prod_old  = PROD_W'(alpha_eff) * PROD_W'(run_est_reg);
        prod_new  = PROD_W'(ALPHA_ONE - alpha_eff) * PROD_W'(elapsed_reg);
        blend_sum = (PROD_W+1)'(prod_old) + (PROD_W+1)'(prod_new) + (PROD_W+1)'(128);
        blend_est = blend_sum[EST_W+7:8];
        stays     = policy_reg && ((run_est_reg < best_est_reg) ||
                    (run_est_reg == best_est_reg && run_pid_reg < best_pid_reg));
    end

    always_comb
    begin
        valid_next     = valid_reg;
        counter_next   = counter_reg;
        run_valid_next = run_valid_reg;
        run_pid_next   = run_pid_reg;
        run_est_next   = run_est_reg;
        elapsed_next   = elapsed_reg;
        pending_next   = pending_reg;
        admitted_next  = admitted_reg;
        a_valid_next   = a_valid_reg;
        a_next         = a_reg;
        d_valid_next   = d_valid_reg;
        d_next         = d_reg;
        tbl_we         = 1'b0;
        tbl_widx       = free_idx_reg;
        tbl_wpid       = run_pid_reg;
        tbl_west       = run_est_reg;

        if (cmd.load)
        begin
            a_valid_next  = 1'b0;
            d_valid_next  = 1'b0;
            admitted_next = 1'b0;
        end

        if (cmd.act)
        begin
            case (item_reg.mode)
                MODE_ADMIT:
                begin
                    if (free_found_reg)
                    begin
                        tbl_we        = 1'b1;
                        tbl_wpid      = item_reg.task_id;
                        tbl_west      = item_reg.initial_estimate;
                        admitted_next = 1'b1;
                    end
                    else
                    begin
                        a_valid_next = 1'b1;
                        a_next = '{EV_REJECT, item_reg.task_id,
                                   item_reg.initial_estimate, 1'b0};
                    end
                end
                MODE_TICK:
                begin
                    if (run_valid_reg && elapsed_reg != EST_MAX)
                    begin
                        elapsed_next = elapsed_reg + 1'b1;
                    end
                end
                MODE_PREEMPT:
                begin
                    if (run_valid_reg)
                    begin
                        elapsed_next = '0;
                        pending_next = 1'b0;
                        if (free_found_reg)
                        begin
                            tbl_we         = 1'b1;
                            run_valid_next = 1'b0;
                        end
                        else
                        begin
                            // Table full: the running task competes with the best entry.
                            if (!stays)
                            begin
                                tbl_we       = 1'b1;
                                tbl_widx     = best_idx_reg;
                                run_pid_next = best_pid_reg;
                                run_est_next = best_est_reg;
                            end
                            a_valid_next = 1'b1;
                            a_next = '{EV_DISPATCH, run_pid_next, run_est_next, 1'b0};
                        end
                    end
                end
                MODE_BLOCK:
                begin
                    if (run_valid_reg)
                    begin
                        run_est_next   = blend_est;
                        a_valid_next   = 1'b1;
                        a_next         = '{EV_BLOCKED, run_pid_reg, blend_est, 1'b0};
                        run_valid_next = 1'b0;
                        elapsed_next   = '0;
                        pending_next   = 1'b0;
                    end
                end
                MODE_FINISH:
                begin
                    if (run_valid_reg)
                    begin
                        a_valid_next   = 1'b1;
                        a_next         = '{EV_FINISHED, run_pid_reg, run_est_reg, 1'b0};
                        run_valid_next = 1'b0;
                        elapsed_next   = '0;
                        pending_next   = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
            if (tbl_we)
            begin
                valid_next[tbl_widx] = 1'b1;
                counter_next         = counter_reg + 1'b1;
            end
        end

        if (cmd.post)
        begin
            if (admitted_reg && run_valid_reg && policy_reg && !pending_reg &&
                best_found_reg && elapsed_reg != '0 && elapsed_reg < run_est_reg &&
                best_est_reg < run_est_reg - elapsed_reg)
            begin
                pending_next = 1'b1;
                a_valid_next = 1'b1;
                a_next       = '{EV_PREEMPT, run_pid_reg, run_est_reg, 1'b0};
            end
            if (!run_valid_reg && best_found_reg)
            begin
                valid_next[best_idx_reg] = 1'b0;
                run_valid_next = 1'b1;
                run_pid_next   = best_pid_reg;
                run_est_next   = best_est_reg;
                elapsed_next   = '0;
                pending_next   = 1'b0;
                d_valid_next   = 1'b1;
                d_next         = '{EV_DISPATCH, best_pid_reg, best_est_reg, 1'b1};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            counter_reg   <= '0;
            run_valid_reg <= 1'b0;
            run_pid_reg   <= '0;
            run_est_reg   <= '0;
            elapsed_reg   <= '0;
            pending_reg   <= 1'b0;
            admitted_reg  <= 1'b0;
            a_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            policy_reg    <= 1'b1;
            alpha_reg     <= ALPHA_RESET;
        end
        else
        begin
            valid_reg     <= valid_next;
            counter_reg   <= counter_next;
            run_valid_reg <= run_valid_next;
            run_pid_reg   <= run_pid_next;
            run_est_reg   <= run_est_next;
            elapsed_reg   <= elapsed_next;
            pending_reg   <= pending_next;
            admitted_reg  <= admitted_next;
            a_valid_reg   <= a_valid_next;
            d_valid_reg   <= d_valid_next;
            if (cfg_we && cfg_index == CFG_POLICY)
            begin
                policy_reg <= cfg_wdata[0];
            end
            if (cfg_we && cfg_index == CFG_ALPHA)
            begin
                alpha_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        d_reg <= d_next;
        if (cmd.load)
        begin
            item_reg <= in_data;
        end
        if (tbl_we)
        begin
            tbl_pid[tbl_widx]   <= tbl_wpid;
            tbl_est[tbl_widx]   <= tbl_west;
            tbl_order[tbl_widx] <= counter_reg;
        end
    end

    // Result queue.
    always_comb
    begin
        q_push  = cmd.push_a || cmd.push_d;
        q_pop   = out_valid && out_ready;
        q_wdata = d_reg;
        if (cmd.push_a)
        begin
            q_wdata      = a_reg;
            q_wdata.last = !d_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wp_reg  <= 1'b0;
            q_rp_reg  <= 1'b0;
            q_cnt_reg <= '0;
        end
        else
        begin
            if (q_push)
            begin
                q_wp_reg <= !q_wp_reg;
            end
            if (q_pop)
            begin
                q_rp_reg <= !q_rp_reg;
            end
            q_cnt_reg <= q_cnt_reg + {1'b0, q_push} - {1'b0, q_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push)
        begin
            q_mem[q_wp_reg] <= q_wdata;
        end
    end

    assign out_valid = (q_cnt_reg != 2'd0);
    assign out_data  = q_mem[q_rp_reg];

    assign stat.scan_last = (idx_reg == IDX_W'(READY_DEPTH - 1));
    assign stat.a_valid   = a_valid_reg;
    assign stat.d_valid   = d_valid_reg;
    assign stat.q_full    = (q_cnt_reg == 2'd2);

    a_pend_run: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg |-> run_valid_reg)
        else $error("preemption pending with nothing running");

    a_elapsed_run: assert property (@(posedge clk) disable iff (!rst_n)
        (elapsed_reg != '0) |-> run_valid_reg)
        else $error("elapsed time counted with nothing running");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (q_cnt_reg != 2'd3) && !(q_push && q_cnt_reg == 2'd2 && !q_pop))
        else $error("result queue overflow");

endmodule

// File: hw/rtl/srt_scheduler_with_burst_estimate.sv
// An item's results enter the output queue once both scans of the ready table and the
// post step are done; an event of the item's own is pushed ahead of its dispatch. The
// block takes no new item until the results of the last one are in the output queue.
// Reset (rst_n, asynchronous, active low) empties the ready table and stops the running task;
// policy returns to shortest remaining time and alpha to one half.
module srt_scheduler_with_burst_estimate (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  srtsbe_pkg::in_t       in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output srtsbe_pkg::out_t      out_data,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [srtsbe_pkg::ALPHA_W-1:0] cfg_wdata
);
    import srtsbe_pkg::*;

    // The controller sequences each item through two table scans: the first finds a free
    // slot and the best waiting task before the item acts, the second finds the best task
    // after it, which is needed for the preemption check and for dispatching.
    cmd_t  cmd;
    stat_t stat;

    srtsbe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the table, the running task, the configuration and a two-entry
    // result queue, so that results of one item may wait while the next item is taken.
    srtsbe_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

endmodule

// File: tb/sv/srtsbe_checker.sv
module srtsbe_checker
    import srtsbe_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    input  logic   in_ready,
    input  in_t    in_data,
    input  logic   out_valid,
    input  logic   out_ready,
    input  out_t   out_data,
    input  logic   cfg_we,
    input  logic   cfg_index,
    input  logic [ALPHA_W-1:0] cfg_wdata,
    output int     fail_count,
    output int     results_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [PID_W-1:0] tbl_pid [READY_DEPTH];
    logic [EST_W-1:0] tbl_est [READY_DEPTH];
    logic [ORD_W-1:0] tbl_ord [READY_DEPTH];
    bit               tbl_used [READY_DEPTH];
    logic [ORD_W-1:0] stamp;
    bit               run_on;
    logic [PID_W-1:0] run_pid;
    logic [EST_W-1:0] run_est;
    logic [EST_W-1:0] elapsed;
    bit               req_raised;
    bit               srt_mode;
    logic [ALPHA_W-1:0] weight;

    out_t owed_results [$];
    out_t step_results [$];

    function automatic logic [ORD_W-1:0] age(int i);
        return ORD_W'(stamp - tbl_ord[i]);
    endfunction

    // True when entry a is to run before entry b.
    function automatic bit runs_first(int a, int b);
        if (srt_mode)
        begin
            if (tbl_est[a] != tbl_est[b])
                return tbl_est[a] < tbl_est[b];
            if (tbl_pid[a] != tbl_pid[b])
                return tbl_pid[a] < tbl_pid[b];
        end
        return age(a) > age(b);
    endfunction

    function automatic int best_waiting();
        int b;
        b = -1;
        for (int i = 0; i < READY_DEPTH; i++)
            if (tbl_used[i] && (b < 0 || runs_first(i, b)))
                b = i;
        return b;
    endfunction

    function automatic int first_free();
        for (int i = 0; i < READY_DEPTH; i++)
            if (!tbl_used[i])
                return i;
        return -1;
    endfunction

    function automatic void enter(int i, logic [PID_W-1:0] pid, logic [EST_W-1:0] est);
        tbl_pid[i]  = pid;
        tbl_est[i]  = est;
        tbl_ord[i]  = stamp;
        tbl_used[i] = 1'b1;
        stamp       = stamp + 1'b1;
    endfunction

    function automatic void note(logic [2:0] ev, logic [PID_W-1:0] pid, logic [EST_W-1:0] est);
        out_t r;
        r.event_res    = ev;
        r.task_out     = pid;
        r.estimate_out = est;
        r.last         = 1'b0;
        step_results.push_back(r);
    endfunction

    function automatic void launch(logic [PID_W-1:0] pid, logic [EST_W-1:0] est);
        run_on     = 1'b1;
        run_pid    = pid;
        run_est    = est;
        elapsed    = '0;
        req_raised = 1'b0;
    endfunction

    function automatic void halt();
        run_on     = 1'b0;
        elapsed    = '0;
        req_raised = 1'b0;
    endfunction

    function automatic void schedule_event(in_t it);
        int s;
        int b;
        bit stays;
        logic [PID_W-1:0] np;
        logic [EST_W-1:0] ne;
        logic [63:0] a;
        logic [63:0] sum;
        out_t r;
        step_results.delete();
        case (it.mode)
            MODE_ADMIT:
            begin
                s = first_free();
                if (s < 0)
                    note(EV_REJECT, it.task_id, it.initial_estimate);
                else
                begin
                    enter(s, it.task_id, it.initial_estimate);
                    if (run_on && srt_mode && !req_raised)
                    begin
                        b = best_waiting();
                        if (b >= 0 && elapsed > 0 && elapsed < run_est &&
                            tbl_est[b] < run_est - elapsed)
                        begin
                            req_raised = 1'b1;
                            note(EV_PREEMPT, run_pid, run_est);
                        end
                    end
                end
            end
            MODE_TICK:
                if (run_on && elapsed < EST_MAX)
                    elapsed = elapsed + 1'b1;
            MODE_PREEMPT:
                if (run_on)
                begin
                    s = first_free();
                    if (s >= 0)
                    begin
                        enter(s, run_pid, run_est);
                        halt();
                    end
                    else
                    begin
                        b = best_waiting();
                        stays = srt_mode && (run_est < tbl_est[b] ||
                                (run_est == tbl_est[b] && run_pid < tbl_pid[b]));
                        if (!stays)
                        begin
                            np = tbl_pid[b];
                            ne = tbl_est[b];
                            enter(b, run_pid, run_est);
                            launch(np, ne);
                        end
                        else
                            launch(run_pid, run_est);
                        note(EV_DISPATCH, run_pid, run_est);
                    end
                end
            MODE_BLOCK:
                if (run_on)
                begin
                    a = (weight > ALPHA_ONE) ? 64'd256 : 64'(weight);
                    sum = a * 64'(run_est) + (64'd256 - a) * 64'(elapsed) + 64'd128;
                    run_est = EST_W'(sum >> 8);
                    note(EV_BLOCKED, run_pid, run_est);
                    halt();
                end
            MODE_FINISH:
                if (run_on)
                begin
                    note(EV_FINISHED, run_pid, run_est);
                    halt();
                end
            default:
                ;
        endcase
        if (!run_on)
        begin
            b = best_waiting();
            if (b >= 0)
            begin
                tbl_used[b] = 1'b0;
                launch(tbl_pid[b], tbl_est[b]);
                note(EV_DISPATCH, run_pid, run_est);
            end
        end
        for (int i = 0; i < step_results.size(); i++)
        begin
            r = step_results[i];
            r.last = (i == step_results.size() - 1);
            owed_results.push_back(r);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < READY_DEPTH; i++)
                tbl_used[i] = 1'b0;
            stamp      = '0;
            run_on     = 1'b0;
            run_pid    = '0;
            run_est    = '0;
            elapsed    = '0;
            req_raised = 1'b0;
            srt_mode   = 1'b1;
            weight     = ALPHA_RESET;
            owed_results.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_POLICY)
                    srt_mode = cfg_wdata[0];
                else
                    weight = cfg_wdata;
            end
            if (in_valid && in_ready)
                schedule_event(in_data);
            if (out_valid && out_ready)
            begin
                if (owed_results.size() == 0)
                begin
                    $display("%0t unexpected result: expected none, got %h", $time, out_data);
                    fail_count++;
                end
                else
                begin
                    if (out_data !== owed_results[0])
                    begin
                        $display("%0t mismatch: expected ev %0d pid %h est %h last %b, got ev %0d pid %h est %h last %b",
                                 $time, owed_results[0].event_res, owed_results[0].task_out,
                                 owed_results[0].estimate_out, owed_results[0].last,
                                 out_data.event_res, out_data.task_out,
                                 out_data.estimate_out, out_data.last);
                        fail_count++;
                    end
                    void'(owed_results.pop_front());
                end
            end
        end
        results_owed = owed_results.size();
    end

endmodule

// File: tb/sv/testbench.sv
module testbench;
    import srtsbe_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // The block scans the ready table twice before an item shows any result, so SETTLE
    // quiet cycles are allowed after the last result before touching the registers.
    localparam int SETTLE    = 2 * READY_DEPTH + 10;
    // Longest stretch with no item moving on either channel before the run is abandoned.
    localparam int WATCHDOG  = 3000;
    localparam int SEG_ITEMS = 94;

    logic   clk;
    logic   rst_n;
    logic   in_valid;
    logic   in_ready;
    in_t    in_data;
    logic   out_valid;
    logic   out_ready;
    out_t   out_data;
    logic   cfg_we;
    logic   cfg_index;
    logic [ALPHA_W-1:0] cfg_wdata;
    int     fail_count;
    int     results_owed;
    int     send_idle;
    int     recv_idle;
    int     quiet_cycles;

    srt_scheduler_with_burst_estimate i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    srtsbe_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .fail_count   (fail_count),
        .results_owed (results_owed)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // The receiver refuses results at random, at the rate set for the current phase.
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle);
    end

    // Watchdog: any cycle in which an item moves on either channel resets the count.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic in_t make_item(logic [2:0] mode, logic [PID_W-1:0] pid,
                                      logic [EST_W-1:0] est);
        in_t it;
        it.mode             = mode;
        it.task_id          = pid;
        it.initial_estimate = est;
        return it;
    endfunction

    // Offers one item, with a random gap first, and returns once it has been taken. The
    // valid line is only lowered when a gap is drawn, so back-to-back items keep it high.
    task automatic offer(in_t it);
        if ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Holds the sender back until every result has come, then lets the block go quiet.
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (results_owed != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_regs(logic srt, logic [ALPHA_W-1:0] a);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_POLICY;
        cfg_wdata <= ALPHA_W'(srt);
        @(posedge clk);
        cfg_index <= CFG_ALPHA;
        cfg_wdata <= a;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Estimates are mostly small so that ties, preemption requests and the blocking
    // average all come up often; the extremes and wide random values are mixed in.
    function automatic logic [EST_W-1:0] pick_estimate();
        int r;
        r = $urandom_range(99);
        if (r < 65)
            return EST_W'($urandom_range(63));
        if (r < 75)
            return '0;
        if (r < 85)
            return EST_MAX;
        return EST_W'($urandom);
    endfunction

    function automatic logic [PID_W-1:0] pick_pid();
        if ($urandom_range(99) < 60)
            return PID_W'($urandom_range(7));
        return PID_W'($urandom);
    endfunction

    function automatic in_t random_item();
        int r;
        r = $urandom_range(99);
        if (r < 35)
            return make_item(MODE_ADMIT, pick_pid(), pick_estimate());
        if (r < 65)
            return make_item(MODE_TICK, PID_W'($urandom), EST_W'($urandom));
        if (r < 75)
            return make_item(MODE_PREEMPT, PID_W'($urandom), EST_W'($urandom));
        if (r < 85)
            return make_item(MODE_BLOCK, PID_W'($urandom), EST_W'($urandom));
        if (r < 95)
            return make_item(MODE_FINISH, PID_W'($urandom), EST_W'($urandom));
        // Unused modes are ignored by the block.
        return make_item(3'($urandom_range(7, 5)), PID_W'($urandom), EST_W'($urandom));
    endfunction

    logic                srt_list   [9] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    logic [ALPHA_W-1:0]  alpha_list [9] = '{9'd128, 9'd0, 9'd256, 9'd0, 9'd511,
                                            9'd200, 9'd1, 9'd128, 9'd300};

    initial
    begin
        int sent;
        in_valid     = 1'b0;
        in_data      = '0;
        out_ready    = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_POLICY;
        cfg_wdata    = '0;
        send_idle    = 12;
        recv_idle    = 68;
        quiet_cycles = 0;
        rst_n        = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset settings: events with nothing running, an unused
        // mode, the widest pid and estimate, a preemption request and the one-request
        // rule, a preemption that dispatches the smaller task, blocking and finishing.
        offer(make_item(MODE_FINISH, '1, '1));
        offer(make_item(MODE_BLOCK, '0, '0));
        offer(make_item(MODE_PREEMPT, '0, '0));
        offer(make_item(3'd7, '1, '1));
        offer(make_item(MODE_ADMIT, '1, EST_MAX));
        offer(make_item(MODE_TICK, '0, '0));
        offer(make_item(MODE_TICK, '0, '0));
        offer(make_item(MODE_TICK, '0, '0));
        offer(make_item(MODE_ADMIT, '0, '0));
        offer(make_item(MODE_ADMIT, 16'd1, '0));
        offer(make_item(MODE_PREEMPT, '0, '0));
        offer(make_item(MODE_TICK, '0, '0));
        offer(make_item(MODE_TICK, '0, '0));
        offer(make_item(MODE_BLOCK, '0, '0));
        offer(make_item(MODE_FINISH, '0, '0));
        offer(make_item(MODE_FINISH, '0, '0));

        // Random part, in segments at differing settings; the idle rates follow the
        // three phases: sender seldom and receiver often, then swapped, then neither.
        for (int seg = 0; seg < 9; seg++)
        begin
            write_regs(srt_list[seg], alpha_list[seg]);
            send_idle = (seg < 3) ? 12 : (seg < 6) ? 68 : 0;
            recv_idle = (seg < 3) ? 68 : (seg < 6) ? 12 : 0;
            sent = 0;
            while (sent < SEG_ITEMS)
            begin
                if ($urandom_range(99) < 4)
                begin
                    // A burst of admissions fills the table, so rejections and the
                    // preemption of a task into a full table are reached.
                    for (int k = 0; k < READY_DEPTH + 2; k++)
                        offer(make_item(MODE_ADMIT, pick_pid(), pick_estimate()));
                    sent += READY_DEPTH + 2;
                end
                else
                begin
                    offer(random_item());
                    sent++;
                end
            end
        end

        drain();
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
